// File: rtl/command_packet_deframer_xor_assert.svh
// assertion macros shared by the deframer checker
`ifndef COMMAND_PACKET_DEFRAMER_XOR_ASSERT_SVH
`define COMMAND_PACKET_DEFRAMER_XOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CPDX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CPDX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cpdx_pkg.sv
`default_nettype none

package cpdx_pkg;

    localparam int PAYLOAD_LEN = 12;
    localparam int NUM_WORDS   = 3;
    localparam int COUNT_W     = 4;

    typedef logic [7:0]         t_byte;
    typedef logic [31:0]        t_word;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_byte HEADER_RESET = 8'hff;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_CHECK = 1'b1;

    localparam t_count LAST_PAYLOAD = t_count'(PAYLOAD_LEN - 1);

endpackage

`default_nettype wire

// File: rtl/cpdx_if.sv
`default_nettype none

// received byte channel
interface cpdx_in_if
    import cpdx_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded command channel
interface cpdx_out_if
    import cpdx_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  status;
    t_word linear_x_bits;
    t_word linear_y_bits;
    t_word angular_bits;

    modport source (output valid, output status, output linear_x_bits,
                    output linear_y_bits, output angular_bits, input ready);
    modport sink   (input valid, input status, input linear_x_bits,
                    input linear_y_bits, input angular_bits, output ready);
endinterface

`default_nettype wire

// File: rtl/command_packet_deframer_xor.sv
// command packet deframer with xor check byte
// i_rx carries received serial bytes, one byte per item (valid/ready)
// o_cmd carries one decoded command per packet: status plus three 32-bit
// words (linear x, linear y, angular), raw single-precision bits
// packet: two header bytes equal to the header register, 12 payload bytes
// (three little-endian words), then one check byte equal to the payload xor
// a good check byte updates the held words and reports status ok, a bad one
// reports bad_check with the previously accepted words (zero after reset)
// i_cfg_wr_en / i_cfg_wr_data write the header register, reset value 0xff
// throughput: one byte per cycle while i_rx.ready is high, set by the single framing register stage
// the command is registered and appears in the cycle after its check byte is accepted
// the result sits in an output register; while it waits, bytes that carry
// no result keep flowing only if o_cmd.ready is high, otherwise i_rx.ready
// drops until the command is taken
// reset (synchronous, active low) returns to hunting the first header,
// clears the held words and drops o_cmd.valid; the payload store is not reset
`default_nettype none

module command_packet_deframer_xor
    import cpdx_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    cpdx_in_if.sink     i_rx,
    cpdx_out_if.source  o_cmd,
    input  wire         i_cfg_wr_en,
    input  wire  t_byte i_cfg_wr_data
);

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_DATA,
        PH_CHECK
    } t_phase;

    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    t_byte  r_xor, n_xor;
    t_byte  r_header;
    t_word  r_words [NUM_WORDS];
    t_word  n_words [NUM_WORDS];
    logic   r_out_valid, n_out_valid;
    logic   r_status, n_status;

    // payload bytes, written in arrival order, no reset
    t_byte  r_store [PAYLOAD_LEN];

    logic   w_accept;
    logic   w_store_wr;
    t_byte  w_byte;

    // the output register frees up when its command is taken
    assign i_rx.ready = !r_out_valid || o_cmd.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_byte     = i_rx.rx_byte;
    assign w_store_wr = w_accept && (r_phase == PH_DATA);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_xor       = r_xor;
        n_words     = r_words;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_cmd.ready;

        if (w_accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (w_byte == r_header) begin
                        n_phase = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (w_byte == r_header) begin
                        n_phase = PH_DATA;
                        n_count = '0;
                        n_xor   = '0;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_DATA: begin
                    n_xor   = r_xor ^ w_byte;
                    n_count = r_count + t_count'(1);
                    if (r_count == LAST_PAYLOAD) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    // little-endian assembly of the three words
                    if (w_byte == r_xor) begin
                        for (int w = 0; w < NUM_WORDS; w++) begin
                            n_words[w] = {r_store[4*w+3], r_store[4*w+2],
                                          r_store[4*w+1], r_store[4*w]};
                        end
                        n_status = STATUS_OK;
                    end else begin
                        n_status = STATUS_BAD_CHECK;
                    end
                    n_out_valid = 1'b1;
                    n_phase     = PH_HUNT1;
                    n_count     = '0;
                    n_xor       = '0;
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_count     <= '0;
            r_xor       <= '0;
            r_header    <= HEADER_RESET;
            r_out_valid <= 1'b0;
            r_status    <= STATUS_OK;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_words[w] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_words     <= n_words;
            // header change applies from the next comparison on
            if (i_cfg_wr_en) begin
                r_header <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_store[r_count] <= w_byte;
        end
    end

    // words are held between packets, so they drive the port directly
    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.status        = r_status;
    assign o_cmd.linear_x_bits = r_words[0];
    assign o_cmd.linear_y_bits = r_words[1];
    assign o_cmd.angular_bits  = r_words[2];

endmodule

`default_nettype wire

// File: rtl/cpdx_checker.sv
`default_nettype none

`include "command_packet_deframer_xor_assert.svh"

module cpdx_checker
    import cpdx_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_rx_valid,
    input wire        i_rx_ready,
    input wire        i_cmd_valid,
    input wire        i_cmd_ready,
    input wire        i_cmd_status,
    input wire t_word i_cmd_linear_x,
    input wire t_word i_cmd_linear_y,
    input wire t_word i_cmd_angular
);

    logic w_rx_acc;
    logic w_cmd_stall;

    assign w_rx_acc    = i_rx_valid && i_rx_ready;
    assign w_cmd_stall = i_cmd_valid && !i_cmd_ready;

    // a stalled command keeps its contents
    `CPDX_ASSERT_NEXT(a_cmd_hold, w_cmd_stall, i_cmd_valid && $stable(i_cmd_status) && $stable(i_cmd_linear_x) && $stable(i_cmd_linear_y) && $stable(i_cmd_angular), "stalled command changed")

    // input backpressure only comes from a waiting command
    `CPDX_ASSERT_SAME(a_ready_src, !i_rx_ready, i_cmd_valid, "input stalled with no command pending")

    // a new command only follows an accepted byte
    `CPDX_ASSERT_SAME(a_cmd_cause, $rose(i_cmd_valid), $past(w_rx_acc), "command without a byte")

    // a taken command is replaced only by one caused by an accepted byte
    `CPDX_ASSERT_NEXT(a_cmd_drain, i_cmd_valid && i_cmd_ready && !w_rx_acc, !i_cmd_valid, "command repeated")

endmodule

bind command_packet_deframer_xor cpdx_checker u_cpdx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx.valid),
    .i_rx_ready     (i_rx.ready),
    .i_cmd_valid    (o_cmd.valid),
    .i_cmd_ready    (o_cmd.ready),
    .i_cmd_status   (o_cmd.status),
    .i_cmd_linear_x (o_cmd.linear_x_bits),
    .i_cmd_linear_y (o_cmd.linear_y_bits),
    .i_cmd_angular  (o_cmd.angular_bits)
);

`default_nettype wire

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cpdx_pkg::*;

    // stimulus sizing and time limits
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int NUM_PHASES     = 4;
    localparam int PHASE_ITEMS    = 270;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_OFF       = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_LEN        = 33;

    // framing phases of the deframer
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT,
        AWAIT_CHECK
    } t_frame_phase;

    // one decoded command
    typedef struct packed {
        logic  status;
        t_word lin_x;
        t_word lin_y;
        t_word ang;
    } t_cmd;

    // one row of the directed table: a byte, and where known, its command
    typedef struct packed {
        t_byte data;
        bit    typed;
        t_cmd  cmd;
    } t_dir_row;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_wr_en;
    t_byte cfg_wr_data;

    cpdx_in_if  rx_bus ();
    cpdx_out_if cmd_bus ();

    command_packet_deframer_xor dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx          (rx_bus),
        .o_cmd         (cmd_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // deframer model state
    t_byte        hdr_model;
    t_frame_phase phase;
    t_count       payload_cnt;
    t_byte        payload_xor;
    t_byte        payload_bytes [PAYLOAD_LEN];
    t_word        held_words [NUM_WORDS];

    // commands waiting for the dut, oldest first
    t_cmd cmd_expect_q [$];

    int  mismatch_count = 0;
    int  sent_count     = 0;
    int  quiet_cycles   = 0;
    bit  feed_gaps_on   = 1'b1;
    bit  drain_stalls_on = 1'b1;
    bit  hold_off_req   = 1'b0;

    t_dir_row dir_rows [DIR_LEN];

    function automatic t_dir_row plain(input t_byte data);
        t_dir_row row;
        row       = '0;
        row.data  = data;
        return row;
    endfunction

    function automatic t_dir_row known(input t_byte data, input logic status,
                                       input t_word x, input t_word y, input t_word a);
        t_dir_row row;
        row.data  = data;
        row.typed = 1'b1;
        row.cmd   = '{status, x, y, a};
        return row;
    endfunction

    // assemble a little-endian word from the payload store
    function automatic t_word payload_word(input int base);
        return {payload_bytes[base + 3], payload_bytes[base + 2],
                payload_bytes[base + 1], payload_bytes[base]};
    endfunction

    // advance the model by one received byte; returns 1 when a command results
    function automatic bit deframe_byte(input t_byte data, output t_cmd res);
        bit match;
        res = '0;
        case (phase)
            HUNT_FIRST: begin
                if (data == hdr_model) phase = HUNT_SECOND;
                return 1'b0;
            end
            HUNT_SECOND: begin
                if (data == hdr_model) begin
                    phase       = COLLECT;
                    payload_cnt = '0;
                    payload_xor = '0;
                end else begin
                    phase = HUNT_FIRST;
                end
                return 1'b0;
            end
            COLLECT: begin
                if (payload_cnt < PAYLOAD_LEN) payload_bytes[payload_cnt] = data;
                payload_xor = payload_xor ^ data;
                payload_cnt = payload_cnt + t_count'(1);
                if (payload_cnt >= PAYLOAD_LEN) phase = AWAIT_CHECK;
                return 1'b0;
            end
            default: begin
                match = (data == payload_xor);
                if (match) begin
                    for (int w = 0; w < NUM_WORDS; w++) held_words[w] = payload_word(4 * w);
                end
                res.status = match ? STATUS_OK : STATUS_BAD_CHECK;
                res.lin_x  = held_words[0];
                res.lin_y  = held_words[1];
                res.ang    = held_words[2];
                phase       = HUNT_FIRST;
                payload_cnt = '0;
                payload_xor = '0;
                return 1'b1;
            end
        endcase
    endfunction

    // offer one byte, wait for its handshake, then record what it should produce
    task automatic send_byte(input t_byte data, input bit use_table, input t_cmd table_cmd);
        t_cmd predicted;
        if (feed_gaps_on && $urandom_range(0, 5) == 0) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= data;
        @(posedge clk);
        while (!rx_bus.ready) @(posedge clk);
        sent_count++;
        if (deframe_byte(data, predicted))
            cmd_expect_q.push_back(use_table ? table_cmd : predicted);
    endtask

    // stop feeding and wait until every pending command has come out
    task automatic drain_pending();
        rx_bus.valid <= 1'b0;
        while (cmd_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new header value, written only while the block is idle
    task automatic program_header(input t_byte value);
        drain_pending();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        hdr_model    = value;
    endtask

    // one random unit: mostly well-formed packets, some noise and broken framing
    task automatic send_frame(input t_byte hdr);
        int    kind;
        t_byte data;
        t_byte sum;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // loose noise bytes
            repeat ($urandom_range(1, 4)) send_byte(t_byte'($urandom_range(0, 255)), 1'b0, '0);
        end else if (kind == 1) begin
            // first header followed by a wrong second header
            send_byte(hdr, 1'b0, '0);
            send_byte(hdr ^ t_byte'($urandom_range(1, 255)), 1'b0, '0);
        end else begin
            send_byte(hdr, 1'b0, '0);
            send_byte(hdr, 1'b0, '0);
            sum = '0;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                // lean toward header-valued and extreme payload bytes
                case ($urandom_range(0, 7))
                    0:       data = hdr;
                    1:       data = 8'h00;
                    2:       data = 8'hff;
                    default: data = t_byte'($urandom_range(0, 255));
                endcase
                sum = sum ^ data;
                send_byte(data, 1'b0, '0);
            end
            // about one packet in four carries a corrupt check byte
            if ($urandom_range(0, 3) == 0) sum = sum ^ t_byte'($urandom_range(1, 255));
            send_byte(sum, 1'b0, '0);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        cmd_bus.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                // long hold so the output register fills and input backs up
                hold_off_req   = 1'b0;
                cmd_bus.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end else if (drain_stalls_on && $urandom_range(0, 3) == 0) begin
                cmd_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                cmd_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // compare each taken command against the oldest expectation
    always @(posedge clk) begin
        t_cmd want;
        if (rst_n && cmd_bus.valid && cmd_bus.ready) begin
            if (cmd_expect_q.size() == 0) begin
                $error("command item with nothing pending: status %0d", cmd_bus.status);
                mismatch_count++;
            end else begin
                want = cmd_expect_q.pop_front();
                if (cmd_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, cmd_bus.status);
                    mismatch_count++;
                end
                if (cmd_bus.linear_x_bits !== want.lin_x) begin
                    $error("linear_x_bits: expected %08h, got %08h",
                           want.lin_x, cmd_bus.linear_x_bits);
                    mismatch_count++;
                end
                if (cmd_bus.linear_y_bits !== want.lin_y) begin
                    $error("linear_y_bits: expected %08h, got %08h",
                           want.lin_y, cmd_bus.linear_y_bits);
                    mismatch_count++;
                end
                if (cmd_bus.angular_bits !== want.ang) begin
                    $error("angular_bits: expected %08h, got %08h",
                           want.ang, cmd_bus.angular_bits);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge clk) begin
        if (!rst_n || (rx_bus.valid && rx_bus.ready) || (cmd_bus.valid && cmd_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_byte hdr_plan [NUM_PHASES];
        int    phase_start;

        rst_n          <= 1'b0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= '0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;

        // model reset
        hdr_model   = HEADER_RESET;
        phase       = HUNT_FIRST;
        payload_cnt = '0;
        payload_xor = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) payload_bytes[i] = '0;
        for (int w = 0; w < NUM_WORDS; w++) held_words[w] = '0;

        // directed table, header at its reset value
        dir_rows = '{
            plain(8'h7e),                      // non-header while hunting, dropped
            plain(8'hff),
            plain(8'h00),                      // wrong second header, hunt restarts
            plain(8'hff), plain(8'hff),
            // payload holding header-valued bytes, no resync on them
            plain(8'hff), plain(8'hff), plain(8'h00), plain(8'h00),
            plain(8'hff), plain(8'hff), plain(8'h80), plain(8'h01),
            plain(8'h00), plain(8'h00), plain(8'h00), plain(8'h00),
            // bad check before anything was accepted: zero words
            known(8'h00, STATUS_BAD_CHECK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
            plain(8'hff), plain(8'hff),
            plain(8'hff), plain(8'hff), plain(8'hff), plain(8'hff),
            plain(8'h00), plain(8'h00), plain(8'h00), plain(8'h00),
            plain(8'h01), plain(8'h02), plain(8'h03), plain(8'h80),
            // matching check, words taken little-endian
            known(8'h80, STATUS_OK, 32'hffff_ffff, 32'h0000_0000, 32'h8003_0201)
        };

        hdr_plan[0] = 8'h00;
        hdr_plan[1] = t_byte'($urandom_range(1, 254));
        hdr_plan[2] = t_byte'($urandom_range(1, 254));
        hdr_plan[3] = 8'hff;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_LEN; r++)
            send_byte(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].cmd);

        // random phases, each under its own header value
        for (int p = 0; p < NUM_PHASES; p++) begin
            program_header(hdr_plan[p]);
            if (p == 1) hold_off_req = 1'b1;
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                // last stretch runs with no idling on either side
                if (p == NUM_PHASES - 1 && sent_count - phase_start > PHASE_ITEMS / 2) begin
                    feed_gaps_on    = 1'b0;
                    drain_stalls_on = 1'b0;
                end
                send_frame(hdr_plan[p]);
            end
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && cmd_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
